/* design/pld_pkg.sv */
// ----------------------------------------------------------------------------
// pld_pkg
// Shared types and constants for the pulse-per-second lock detector.
// ----------------------------------------------------------------------------
package pld_pkg;

    // Tick counter width and derived limits
    localparam int TICK_WIDTH   = 24;
    localparam int PERIOD_WIDTH = 24;
    localparam int RUN_WIDTH    = 8;
    localparam int TOTAL_WIDTH  = 32;
    localparam int CFG_WIDTH    = 24;
    localparam int CMP_WIDTH    = (TICK_WIDTH > PERIOD_WIDTH) ? TICK_WIDTH : PERIOD_WIDTH;

    localparam logic [TICK_WIDTH-1:0]   TICK_MAX   = {TICK_WIDTH{1'b1}};
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = {PERIOD_WIDTH{1'b1}};
    localparam logic [RUN_WIDTH-1:0]    RUN_MAX    = {RUN_WIDTH{1'b1}};

    // Register reset values
    localparam logic [PERIOD_WIDTH-1:0] MIN_PERIOD_RST   = 24'd800000;
    localparam logic [PERIOD_WIDTH-1:0] MAX_PERIOD_RST   = 24'd1200000;
    localparam logic [RUN_WIDTH-1:0]    LOCK_AFTER_RST   = 8'd3;
    localparam logic [PERIOD_WIDTH-1:0] LOSS_TIMEOUT_RST = 24'd2800000;

    typedef enum logic [1:0] {
        CFG_MIN_PERIOD   = 2'd0,
        CFG_MAX_PERIOD   = 2'd1,
        CFG_LOCK_AFTER   = 2'd2,
        CFG_LOSS_TIMEOUT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] min_period;
        logic [PERIOD_WIDTH-1:0] max_period;
        logic [RUN_WIDTH-1:0]    lock_after;
        logic [PERIOD_WIDTH-1:0] loss_timeout;
    } cfg_t;

    typedef struct packed {
        logic                    locked;
        logic                    pulse_seen;
        logic [RUN_WIDTH-1:0]    good_run;
        logic [TOTAL_WIDTH-1:0]  pulse_total;
        logic [PERIOD_WIDTH-1:0] last_period;
    } status_t;

endpackage

/* design/pld_if.sv */
// ----------------------------------------------------------------------------
// pld_tick_if / pld_status_if
// Valid/ready channels for input ticks and status results.
// ----------------------------------------------------------------------------
interface pld_tick_if;
    logic valid;
    logic ready;
    logic pulse_edge;

    modport source (output valid, output pulse_edge, input ready);
    modport sink   (input valid, input pulse_edge, output ready);
endinterface

interface pld_status_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 locked;
    logic                                 pulse_seen;
    logic [pld_pkg::RUN_WIDTH-1:0]        good_run;
    logic [pld_pkg::TOTAL_WIDTH-1:0]      pulse_total;
    logic [pld_pkg::PERIOD_WIDTH-1:0]     last_period;

    modport source (output valid, output locked, output pulse_seen, output good_run,
                    output pulse_total, output last_period, input ready);
    modport sink   (input valid, input locked, input pulse_seen, input good_run,
                    input pulse_total, input last_period, output ready);
endinterface

/* design/pld_core.sv */
// ----------------------------------------------------------------------------
// pld_core
// Tick counter, good-pulse run and lock state; one update per step.
// ----------------------------------------------------------------------------
module pld_core (
    input  logic             clk,
    input  logic             rst_n,
    input  pld_pkg::cfg_t    cfg,
    input  logic             step,
    input  logic             pulse_edge,
    output pld_pkg::status_t status
);

    logic [pld_pkg::TICK_WIDTH-1:0]   since_reg, since_next;
    logic [pld_pkg::RUN_WIDTH-1:0]    run_reg, run_next;
    logic                             lock_reg, lock_next;
    logic                             seen_reg, seen_next;
    logic [pld_pkg::TOTAL_WIDTH-1:0]  total_reg, total_next;
    logic [pld_pkg::PERIOD_WIDTH-1:0] period_reg, period_next;

    logic [pld_pkg::TICK_WIDTH-1:0]   since_inc;
    logic [pld_pkg::CMP_WIDTH-1:0]    period_ext;
    logic [pld_pkg::CMP_WIDTH-1:0]    since_ext;
    logic                             in_window;
    logic                             lock_gain;

    always_comb
    begin
        since_inc  = (since_reg == pld_pkg::TICK_MAX) ? pld_pkg::TICK_MAX
                                                      : since_reg + 1'b1;
        period_ext = pld_pkg::CMP_WIDTH'(since_inc);
        in_window  = (period_ext >= pld_pkg::CMP_WIDTH'(cfg.min_period)) &&
                     (period_ext <= pld_pkg::CMP_WIDTH'(cfg.max_period));

        since_next  = since_inc;
        run_next    = run_reg;
        period_next = period_reg;
        total_next  = total_reg;
        seen_next   = seen_reg;

        if (pulse_edge)
        begin
            since_next = '0;
            total_next = total_reg + 1'b1;
            seen_next  = 1'b1;
            if (!seen_reg)
            begin
                // first pulse: no period yet
                run_next = pld_pkg::RUN_WIDTH'(1);
            end
            else
            begin
                if (!in_window)
                    run_next = pld_pkg::RUN_WIDTH'(1);
                else if (run_reg != pld_pkg::RUN_MAX)
                    run_next = run_reg + 1'b1;
                period_next = (period_ext > pld_pkg::CMP_WIDTH'(pld_pkg::PERIOD_MAX))
                            ? pld_pkg::PERIOD_MAX
                            : period_ext[pld_pkg::PERIOD_WIDTH-1:0];
            end
        end

        // gain first, then loss
        since_ext = pld_pkg::CMP_WIDTH'(since_next);
        lock_gain = seen_next && (run_next >= cfg.lock_after);
        lock_next = (lock_reg || lock_gain) &&
                    seen_next && (since_ext < pld_pkg::CMP_WIDTH'(cfg.loss_timeout));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_reg  <= '0;
            run_reg    <= '0;
            lock_reg   <= 1'b0;
            seen_reg   <= 1'b0;
            total_reg  <= '0;
            period_reg <= '0;
        end
        else if (step)
        begin
            since_reg  <= since_next;
            run_reg    <= run_next;
            lock_reg   <= lock_next;
            seen_reg   <= seen_next;
            total_reg  <= total_next;
            period_reg <= period_next;
        end
    end

    // state after the last step is the result
    assign status.locked      = lock_reg;
    assign status.pulse_seen  = seen_reg;
    assign status.good_run    = run_reg;
    assign status.pulse_total = total_reg;
    assign status.last_period = period_reg;

endmodule

/* design/pulse_per_second_lock_detector.sv */
// ----------------------------------------------------------------------------
// pulse_per_second_lock_detector
// Lock detector for a pulse-per-second source sampled on microsecond ticks.
// ----------------------------------------------------------------------------
// Order: a tick first sits in the input register, then the state/result register
//   updates once the result register is empty or being drained.
// Throughput: one tick per cycle while status.ready does not stall a held result.
// Reset: state and counters clear, registers return to their default values.
module pulse_per_second_lock_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  pld_pkg::cfg_index_t             cfg_index,
    input  logic [pld_pkg::CFG_WIDTH-1:0]   cfg_data,
    pld_tick_if.sink                        tick,
    pld_status_if.source                    status
);

    pld_pkg::cfg_t    cfg_reg;
    pld_pkg::status_t core_status;

    logic in_valid_reg;
    logic edge_reg;
    logic out_valid_reg;
    logic advance;
    logic step;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_period   <= pld_pkg::MIN_PERIOD_RST;
            cfg_reg.max_period   <= pld_pkg::MAX_PERIOD_RST;
            cfg_reg.lock_after   <= pld_pkg::LOCK_AFTER_RST;
            cfg_reg.loss_timeout <= pld_pkg::LOSS_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pld_pkg::CFG_MIN_PERIOD:
                    cfg_reg.min_period <= cfg_data[pld_pkg::PERIOD_WIDTH-1:0];
                pld_pkg::CFG_MAX_PERIOD:
                    cfg_reg.max_period <= cfg_data[pld_pkg::PERIOD_WIDTH-1:0];
                pld_pkg::CFG_LOCK_AFTER:
                    cfg_reg.lock_after <= cfg_data[pld_pkg::RUN_WIDTH-1:0];
                pld_pkg::CFG_LOSS_TIMEOUT:
                    cfg_reg.loss_timeout <= cfg_data[pld_pkg::PERIOD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // advance when the result register is empty or being drained
    assign advance    = !out_valid_reg || status.ready;
    assign step       = in_valid_reg && advance;
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick.ready)
                in_valid_reg <= tick.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
            edge_reg <= tick.pulse_edge;
    end

    pld_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .step       (step),
        .pulse_edge (edge_reg),
        .status     (core_status)
    );

    assign status.valid       = out_valid_reg;
    assign status.locked      = core_status.locked;
    assign status.pulse_seen  = core_status.pulse_seen;
    assign status.good_run    = core_status.good_run;
    assign status.pulse_total = core_status.pulse_total;
    assign status.last_period = core_status.last_period;

    // lock requires a pulse on record
    a_lock_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        core_status.locked |-> core_status.pulse_seen)
        else $error("lock without any pulse");

    // pulse_seen never drops once set
    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(core_status.pulse_seen))
        else $error("pulse_seen dropped");

    // a seen pulse implies a nonzero run
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        core_status.pulse_seen |-> (core_status.good_run != '0))
        else $error("zero run after a pulse");

    // input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> (out_valid_reg && !status.ready))
        else $error("input stalled without output back-pressure");

endmodule
